>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/bsd_pkg.sv
// Types and constants shared by the BMP decoder modules.
package bsd_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ROW    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_SIGNATURE = 3'd0;
    localparam logic [2:0] ERR_DEPTH     = 3'd1;
    localparam logic [2:0] ERR_SHORT     = 3'd2;
    localparam logic [2:0] ERR_SIZE      = 3'd3;
    localparam logic [2:0] ERR_OFFSET    = 3'd4;
    localparam logic [2:0] ERR_TRUNC     = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_PIXEL  = 6'b000100,
        PH_PAD    = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_ERROR  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] argb;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  error_code;
        logic        image_complete;
    } t_result;

    // All results caused by one input byte.
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_entry;

endpackage

>>> rtl/core/bmp_stream_to_argb_decoder.sv
// Top level of the BMP byte stream to ARGB pixel decoder.
// Usage:
//   Input channel: one file byte per transfer (i_data_byte, i_end_of_file),
//   taken when i_valid is high and o_stall is low. Output channel: one result
//   per transfer on o_* fields, taken when o_valid is high and i_stall is low.
//   A result is a header report, a pixel with its x and y, a row-done mark or
//   an error; o_run_last flags the last result caused by a byte.
// Path: a taken byte's results are written into the queue, then loaded into
//   the output register, from which they are offered.
// Throughput: one byte per cycle while o_stall is low. A byte with two results
//   (a pixel that ends a row, or a trailing error) sends them as two transfers;
//   the four-entry queue between parser and output stage absorbs these bursts.
// Stall: when the receiver stalls, the output register holds its result and
//   the queue fills; o_stall rises only when the queue is full.
// Reset: synchronous, active low; the parser returns to the header state and
//   the queue and output register empty. End of file also returns the parser
//   to the header state after that byte's results.
// Sizes: MAX_WIDTH and MAX_HEIGHT bound the accepted image size.
module bmp_stream_to_argb_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_argb,
    output logic [11:0] o_dest_x,
    output logic [11:0] o_dest_y,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height,
    output logic [2:0]  o_error_code,
    output logic        o_image_complete,
    output logic        o_run_last
);
    logic             q_push, q_full;
    bsd_pkg::t_entry  push_entry, head;
    bsd_pkg::t_result res;
    logic             empty, pop;

    bsd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_data_byte(i_data_byte), .i_end_of_file(i_end_of_file),
        .i_full(q_full), .o_push(q_push), .o_entry(push_entry)
    );

    bsd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_entry(push_entry),
        .i_pop(pop), .o_head(head), .o_empty(empty), .o_full(q_full)
    );

    bsd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .i_empty(empty),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall), .o_res(res),
        .o_run_last(o_run_last)
    );

    // stall upstream only while the queue has no room
    assign o_stall          = q_full;
    assign o_kind           = res.kind;
    assign o_argb           = res.argb;
    assign o_dest_x         = res.dest_x;
    assign o_dest_y         = res.dest_y;
    assign o_image_width    = res.image_width;
    assign o_image_height   = res.image_height;
    assign o_error_code     = res.error_code;
    assign o_image_complete = res.image_complete;
endmodule

>>> rtl/core/bsd_front.sv
// Header parser and pixel assembler: one byte in, up to two results out.
`include "assert_macros.svh"
module bsd_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_file,
    input  logic            i_full,
    output logic            o_push,
    output bsd_pkg::t_entry o_entry
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    bsd_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_pos, n_pos, r_off, n_off, r_w, n_w, r_h, n_h;
    logic        r_d32, n_d32, r_bup, n_bup;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [1:0]  r_bip, n_bip, r_pad, n_pad;
    logic [23:0] r_asm, n_asm;

    logic          acc;
    logic [1:0]    cnt;
    bsd_pkg::t_result res [0:1];

    assign acc = i_valid && !i_full;

    always_comb begin
        logic        err_v;
        logic [2:0]  err_c;
        logic [31:0] mag;
        logic [31:0] yfl;
        logic [7:0]  alpha;
        logic        lastk;
        logic        last_row;
        bsd_pkg::t_result rr;

        n_phase = r_phase; n_pos = r_pos; n_off = r_off; n_w = r_w; n_h = r_h;
        n_d32 = r_d32; n_bup = r_bup; n_col = r_col; n_row = r_row;
        n_bip = r_bip; n_pad = r_pad; n_asm = r_asm;
        res[0] = '0; res[1] = '0; cnt = 2'd0;
        err_v = 1'b0; err_c = bsd_pkg::ERR_SIGNATURE;
        mag = 32'd0; alpha = 8'd0; lastk = 1'b0; last_row = 1'b0; rr = '0;
        yfl = r_bup ? (r_h - 32'd1 - 32'(r_row)) : 32'(r_row);

        case (r_phase)
            bsd_pkg::PH_HEADER: begin
                if (r_pos == 32'd0 && i_data_byte != 8'h42) err_v = 1'b1;
                if (r_pos == 32'd1 && i_data_byte != 8'h4D) err_v = 1'b1;
                case (r_pos)
                    32'd10: n_off[7:0]   = i_data_byte;
                    32'd11: n_off[15:8]  = i_data_byte;
                    32'd12: n_off[23:16] = i_data_byte;
                    32'd13: n_off[31:24] = i_data_byte;
                    32'd18: n_w[7:0]     = i_data_byte;
                    32'd19: n_w[15:8]    = i_data_byte;
                    32'd20: n_w[23:16]   = i_data_byte;
                    32'd21: n_w[31:24]   = i_data_byte;
                    32'd22: n_h[7:0]     = i_data_byte;
                    32'd23: n_h[15:8]    = i_data_byte;
                    32'd24: n_h[23:16]   = i_data_byte;
                    32'd25: begin
                        n_h[31:24] = i_data_byte;
                        n_bup      = !i_data_byte[7];
                    end
                    default: ;
                endcase
                if (r_pos == 32'd28) begin
                    if (i_data_byte == 8'd32) n_d32 = 1'b1;
                    else if (i_data_byte != 8'd24) begin
                        err_v = 1'b1; err_c = bsd_pkg::ERR_DEPTH;
                    end
                end
                if (r_pos == 32'd29 && i_data_byte != 8'd0) begin
                    err_v = 1'b1; err_c = bsd_pkg::ERR_DEPTH;
                end
                if (r_pos == 32'd53) begin
                    mag = r_bup ? r_h : (32'd0 - r_h);
                    if (r_w == 32'd0 || r_w > 32'(MAX_WIDTH) ||
                        mag == 32'd0 || mag > 32'(MAX_HEIGHT)) begin
                        err_v = 1'b1; err_c = bsd_pkg::ERR_SIZE;
                    end else if (r_off < 32'd54) begin
                        err_v = 1'b1; err_c = bsd_pkg::ERR_OFFSET;
                    end else begin
                        n_h = mag;
                        rr = '0;
                        rr.kind = bsd_pkg::KIND_HEADER;
                        rr.image_width  = r_w[12:0];
                        rr.image_height = mag[12:0];
                        res[0] = rr; cnt = 2'd1;
                        n_phase = (r_off == 32'd54) ? bsd_pkg::PH_PIXEL : bsd_pkg::PH_SKIP;
                    end
                end
                n_pos = r_pos + 32'd1;
                if (err_v) begin
                    rr = '0;
                    rr.kind = bsd_pkg::KIND_ERROR;
                    rr.error_code = err_c;
                    res[0] = rr; cnt = 2'd1;
                    n_phase = bsd_pkg::PH_ERROR;
                end
            end
            bsd_pkg::PH_SKIP: begin
                n_pos = r_pos + 32'd1;
                if (n_pos == r_off) n_phase = bsd_pkg::PH_PIXEL;
            end
            bsd_pkg::PH_PIXEL: begin
                case (r_bip)
                    2'd0: n_asm[7:0]   = i_data_byte;
                    2'd1: n_asm[15:8]  = i_data_byte;
                    2'd2: n_asm[23:16] = i_data_byte;
                    default: ;
                endcase
                lastk = r_d32 ? (r_bip == 2'd3) : (r_bip == 2'd2);
                if (lastk) begin
                    alpha = r_d32 ? i_data_byte : 8'd0;
                    if (alpha == 8'd0) alpha = 8'hFF;
                    rr = '0;
                    rr.kind   = bsd_pkg::KIND_PIXEL;
                    rr.argb   = {alpha, n_asm};
                    rr.dest_x = 12'(r_col);
                    rr.dest_y = yfl[11:0];
                    res[0] = rr; cnt = 2'd1;
                    n_asm = 24'd0;
                    n_bip = 2'd0;
                    n_col = r_col + CW'(1);
                    if (32'(n_col) == r_w) begin
                        n_col = '0;
                        // 24-bit rows pad to 4 bytes: pad = width mod 4
                        if (r_d32 || r_w[1:0] == 2'd0) begin
                            last_row = (32'(r_row) + 32'd1 == r_h);
                            rr = '0;
                            rr.kind = bsd_pkg::KIND_ROW;
                            rr.dest_y = yfl[11:0];
                            rr.image_complete = last_row;
                            res[1] = rr; cnt = 2'd2;
                            n_row = r_row + RW'(1);
                            if (last_row) n_phase = bsd_pkg::PH_DONE;
                        end else begin
                            n_pad = r_w[1:0];
                            n_phase = bsd_pkg::PH_PAD;
                        end
                    end
                end else begin
                    n_bip = r_bip + 2'd1;
                end
            end
            bsd_pkg::PH_PAD: begin
                n_pad = r_pad - 2'd1;
                if (n_pad == 2'd0) begin
                    n_phase = bsd_pkg::PH_PIXEL;
                    last_row = (32'(r_row) + 32'd1 == r_h);
                    rr = '0;
                    rr.kind = bsd_pkg::KIND_ROW;
                    rr.dest_y = yfl[11:0];
                    rr.image_complete = last_row;
                    res[0] = rr; cnt = 2'd1;
                    n_row = r_row + RW'(1);
                    if (last_row) n_phase = bsd_pkg::PH_DONE;
                end
            end
            default: ;
        endcase

        if (i_end_of_file) begin
            rr = '0;
            rr.kind = bsd_pkg::KIND_ERROR;
            if (n_phase == bsd_pkg::PH_HEADER) begin
                rr.error_code = bsd_pkg::ERR_SHORT;
                res[cnt[0]] = rr; cnt = cnt + 2'd1;
            end else if (n_phase == bsd_pkg::PH_SKIP || n_phase == bsd_pkg::PH_PIXEL ||
                         n_phase == bsd_pkg::PH_PAD) begin
                // truncation error takes the place of the row-done of a row that is not the last
                if (cnt == 2'd2) cnt = 2'd1;
                rr.error_code = bsd_pkg::ERR_TRUNC;
                res[cnt[0]] = rr; cnt = cnt + 2'd1;
            end
            n_phase = bsd_pkg::PH_HEADER; n_pos = '0; n_off = '0; n_w = '0;
            n_h = '0; n_d32 = 1'b0; n_bup = 1'b1; n_col = '0; n_row = '0;
            n_bip = '0; n_pad = '0; n_asm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bsd_pkg::PH_HEADER;
            r_pos <= '0; r_off <= '0; r_w <= '0; r_h <= '0;
            r_d32 <= 1'b0; r_bup <= 1'b1; r_col <= '0; r_row <= '0;
            r_bip <= '0; r_pad <= '0; r_asm <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_pos <= n_pos; r_off <= n_off; r_w <= n_w; r_h <= n_h;
            r_d32 <= n_d32; r_bup <= n_bup; r_col <= n_col; r_row <= n_row;
            r_bip <= n_bip; r_pad <= n_pad; r_asm <= n_asm;
        end
    end

    assign o_push         = acc && (cnt != 2'd0);
    assign o_entry.first  = res[0];
    assign o_entry.second = res[1];
    assign o_entry.two    = (cnt == 2'd2);

    `ASSERT_IMPLIES(a_pad_phase, i_clk, i_rst_n, r_phase == bsd_pkg::PH_PAD, r_pad != 2'd0 && !r_d32)
endmodule

>>> rtl/core/bsd_queue.sv
// Short queue of per-byte result groups between parser and output stage.
`include "assert_macros.svh"
module bsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output bsd_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);
    bsd_pkg::t_entry r_mem [0:bsd_pkg::QDEPTH-1];
    logic [bsd_pkg::QAW-1:0] r_wp, r_rp;
    logic [bsd_pkg::QCW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == bsd_pkg::QCW'(bsd_pkg::QDEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + bsd_pkg::QCW'(do_push) - bsd_pkg::QCW'(do_pop);
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= bsd_pkg::QCW'(bsd_pkg::QDEPTH))
    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
endmodule

>>> rtl/core/bsd_back.sv
// Output stage: splits result groups into single transfers, registered.
`include "assert_macros.svh"
module bsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsd_pkg::t_entry  i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output bsd_pkg::t_result o_res,
    output logic             o_run_last
);
    logic             r_valid, r_last, r_have2, out_free;
    bsd_pkg::t_result r_res, r_second;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = out_free && !r_have2 && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_have2 <= 1'b0;
        end else if (out_free) begin
            if (r_have2) begin
                r_valid <= 1'b1; r_have2 <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1; r_have2 <= i_head.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_have2) begin
                r_res <= r_second; r_last <= 1'b1;
            end else if (!i_empty) begin
                r_res <= i_head.first; r_last <= !i_head.two;
                r_second <= i_head.second;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_res      = r_res;
    assign o_run_last = r_last;

    `ASSERT_IMPLIES(a_second_needs_first, i_clk, i_rst_n, r_have2, r_valid && !r_last)
    `ASSERT_NEXT(a_second_held, i_clk, i_rst_n, r_have2 && !out_free, r_have2)
endmodule
